FILE: src/mne_pkg.sv
// ----------------------------------------------------------------------------
// mne_pkg
// Shared types and constants for the multilinear neuron evaluator: Q1.14
// widths, coefficient register indexes and the coefficient set struct.
// ----------------------------------------------------------------------------
`default_nettype none

package mne_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int IDX_W     = 3;
    localparam int SUM_W     = 24;

    // product and term widths through the pipe
    localparam int PROD_W  = 2 * DATA_W;          // x * x, x * coeff
    localparam int PAIR_W  = PROD_W - FRAC_BITS;  // pair term, two bits wider than an input
    localparam int PAIRP_W = PAIR_W + DATA_W;     // pair term * x or coeff
    localparam int TRIP_W  = PAIRP_W - FRAC_BITS - 1;
    localparam int TRIPP_W = TRIP_W + DATA_W;

    localparam logic signed [SUM_W-1:0]  ONE_SUM  = SUM_W'(1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0]  MONE_SUM = -ONE_SUM;
    localparam logic signed [DATA_W-1:0] ONE_OUT  = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] MONE_OUT = -ONE_OUT;

    typedef enum logic [IDX_W-1:0] {
        IDX_BIAS = 3'd0,
        IDX_A    = 3'd1,
        IDX_B    = 3'd2,
        IDX_AB   = 3'd3,
        IDX_C    = 3'd4,
        IDX_AC   = 3'd5,
        IDX_BC   = 3'd6,
        IDX_ABC  = 3'd7
    } coeff_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] bias;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] ab;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] ac;
        logic signed [DATA_W-1:0] bc;
        logic signed [DATA_W-1:0] abc;
    } coeff_set_t;

endpackage

`default_nettype wire

FILE: src/mne_coeff_regs.sv
// ----------------------------------------------------------------------------
// mne_coeff_regs
// Coefficient register file: eight signed Q1.14 coefficients written
// through a plain write port, cleared to zero on reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mne_coeff_regs
    import mne_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_wdata,
    output coeff_set_t             coeffs
);

    coeff_set_t coeffs_reg;
    coeff_set_t coeffs_next;

    always_comb begin
        coeffs_next = coeffs_reg;
        if (cfg_we) begin
            case (coeff_idx_t'(cfg_index))
                IDX_BIAS: coeffs_next.bias = cfg_wdata;
                IDX_A:    coeffs_next.a    = cfg_wdata;
                IDX_B:    coeffs_next.b    = cfg_wdata;
                IDX_AB:   coeffs_next.ab   = cfg_wdata;
                IDX_C:    coeffs_next.c    = cfg_wdata;
                IDX_AC:   coeffs_next.ac   = cfg_wdata;
                IDX_BC:   coeffs_next.bc   = cfg_wdata;
                IDX_ABC:  coeffs_next.abc  = cfg_wdata;
                default:  coeffs_next = coeffs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeffs_reg <= '0;
        end else begin
            coeffs_reg <= coeffs_next;
        end
    end

    assign coeffs = coeffs_reg;

endmodule

`default_nettype wire

FILE: src/multilinear_neuron_eval.sv
// ----------------------------------------------------------------------------
// multilinear_neuron_eval
// Sigma-pi neuron over three Q1.14 inputs with a saturated Q1.14 output.
// ----------------------------------------------------------------------------
// Accepts one beat per clock while s_ready is high and returns one result
// beat per input beat, in order. A beat passes the stage registers in turn:
// input pair products, then input and pair terms times coefficient and pair
// times third input, then triple times its coefficient, then the final add
// and clamp. Each stage stalls only when it holds data the next stage cannot
// take, so bubbles are squeezed out and new beats keep entering while a
// result waits, until the pipe is full. The user must write coefficients
// through the cfg port only while no beat is in flight; the block does not
// enforce this. Writes to them take effect at once. The sum of bias and the
// seven terms is clamped to +/-1.0 and m_clipped flags a clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module multilinear_neuron_eval
    import mne_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [DATA_W-1:0] s_in_a,
    input  wire logic signed [DATA_W-1:0] s_in_b,
    input  wire logic signed [DATA_W-1:0] s_in_c,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_neuron_out,
    output logic                          m_clipped
);

    coeff_set_t coeffs;

    mne_coeff_regs u_coeff_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coeffs    (coeffs)
    );

    // stage enables, each stage moves when empty or the next one moves
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: inputs and pair products
    logic signed [DATA_W-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [PROD_W-1:0] pab1_reg, pac1_reg, pbc1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            a1_reg   <= s_in_a;
            b1_reg   <= s_in_b;
            c1_reg   <= s_in_c;
            pab1_reg <= s_in_a * s_in_b;
            pac1_reg <= s_in_a * s_in_c;
            pbc1_reg <= s_in_b * s_in_c;
        end
    end

    // stage 2: term times coefficient, pair times third input
    logic signed [PAIR_W-1:0] ab1, ac1, bc1;
    assign ab1 = pab1_reg[PROD_W-1:FRAC_BITS];
    assign ac1 = pac1_reg[PROD_W-1:FRAC_BITS];
    assign bc1 = pbc1_reg[PROD_W-1:FRAC_BITS];

    logic signed [PROD_W-1:0]  ma2_reg, mb2_reg, mc2_reg;
    logic signed [PAIRP_W-1:0] mab2_reg, mac2_reg, mbc2_reg, pabc2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            ma2_reg   <= a1_reg * coeffs.a;
            mb2_reg   <= b1_reg * coeffs.b;
            mc2_reg   <= c1_reg * coeffs.c;
            mab2_reg  <= ab1 * coeffs.ab;
            mac2_reg  <= ac1 * coeffs.ac;
            mbc2_reg  <= bc1 * coeffs.bc;
            pabc2_reg <= ab1 * c1_reg;
        end
    end

    // stage 3: triple times coefficient, partial sums
    logic signed [PAIR_W-1:0]            ta2, tb2, tc2;
    logic signed [PAIRP_W-FRAC_BITS-1:0] tab2, tac2, tbc2;
    logic signed [TRIP_W-1:0]            abc2;
    logic signed [SUM_W-1:0]             part_lin, part_pair;

    assign ta2  = ma2_reg[PROD_W-1:FRAC_BITS];
    assign tb2  = mb2_reg[PROD_W-1:FRAC_BITS];
    assign tc2  = mc2_reg[PROD_W-1:FRAC_BITS];
    assign tab2 = mab2_reg[PAIRP_W-1:FRAC_BITS];
    assign tac2 = mac2_reg[PAIRP_W-1:FRAC_BITS];
    assign tbc2 = mbc2_reg[PAIRP_W-1:FRAC_BITS];
    assign abc2 = pabc2_reg[TRIP_W+FRAC_BITS-1:FRAC_BITS];

    assign part_lin  = SUM_W'(coeffs.bias) + SUM_W'(ta2) + SUM_W'(tb2) + SUM_W'(tc2);
    assign part_pair = SUM_W'(tab2) + SUM_W'(tac2) + SUM_W'(tbc2);

    logic signed [SUM_W-1:0]   lin3_reg, pair3_reg;
    logic signed [TRIPP_W-1:0] mabc3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            lin3_reg  <= part_lin;
            pair3_reg <= part_pair;
            mabc3_reg <= abc2 * coeffs.abc;
        end
    end

    // stage 4: final sum and clamp
    logic signed [TRIPP_W-FRAC_BITS-1:0] tabc3;
    logic signed [SUM_W-1:0]             sum3;
    logic signed [DATA_W-1:0]            out_next;
    logic                                clip_next;

    assign tabc3 = mabc3_reg[TRIPP_W-1:FRAC_BITS];
    assign sum3  = lin3_reg + pair3_reg + SUM_W'(tabc3);

    always_comb begin
        out_next  = sum3[DATA_W-1:0];
        clip_next = 1'b0;
        if (sum3 > ONE_SUM) begin
            out_next  = ONE_OUT;
            clip_next = 1'b1;
        end else if (sum3 < MONE_SUM) begin
            out_next  = MONE_OUT;
            clip_next = 1'b1;
        end
    end

    logic signed [DATA_W-1:0] out4_reg;
    logic                     clip4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            out4_reg  <= out_next;
            clip4_reg <= clip_next;
        end
    end

    assign m_valid      = v4_reg;
    assign m_neuron_out = out4_reg;
    assign m_clipped    = clip4_reg;

    // a clamped beat carries exactly plus or minus one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> (m_neuron_out == ONE_OUT || m_neuron_out == MONE_OUT))
        else $error("clipped beat not at full scale");

    // result always inside the clamp range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_neuron_out <= ONE_OUT && m_neuron_out >= MONE_OUT))
        else $error("result beyond full scale");

    // input back-pressure only when the whole pipe is full and the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid && !m_ready))
        else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multilinear_neuron_eval. Coefficients are loaded
// through the cfg port while the pipe is empty. Each accepted input beat is
// run through a local sigma-pi predictor, and the result channel is compared
// field by field in order. Directed beats hit the extreme values, each
// subset term alone and the exact and clamped +/-1.0 sums. Random phases
// follow, under bursty input and a changing output stall pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import mne_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int COEFF_COUNT  = 8;
    localparam int DRAIN_CYCLES = 8;

    typedef logic signed [DATA_W-1:0] q14_t;

    typedef struct {
        q14_t neuron_out;
        logic clipped;
    } neuron_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    q14_t              s_in_a = '0;
    q14_t              s_in_b = '0;
    q14_t              s_in_c = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    q14_t              m_neuron_out;
    logic              m_clipped;

    q14_t           coeff_regs [COEFF_COUNT];
    q14_t           coeff_plan [COEFF_COUNT];
    neuron_result_t pending_results [$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_left = 0;

    multilinear_neuron_eval u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_a       (s_in_a),
        .s_in_b       (s_in_b),
        .s_in_c       (s_in_c),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_neuron_out (m_neuron_out),
        .m_clipped    (m_clipped)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[multilinear_neuron_eval] ERROR");
            $finish;
        end
    end

    // sum of bias and all subset terms, each shift rounding toward -inf
    function automatic neuron_result_t predict_neuron(input q14_t a, input q14_t b,
                                                      input q14_t c);
        longint         x [3];
        longint         one;
        longint         acc;
        longint         term;
        int             subset;
        int             j;
        neuron_result_t r;
        one  = longint'(1) <<< FRAC_BITS;
        x[0] = a;
        x[1] = b;
        x[2] = c;
        acc  = coeff_regs[IDX_BIAS];
        for (subset = 1; subset < COEFF_COUNT; subset++) begin
            term = one;
            for (j = 0; j < 3; j++) begin
                if (((subset >> j) & 1) != 0) begin
                    term = (term * x[j]) >>> FRAC_BITS;
                end
            end
            acc += (term * longint'(coeff_regs[subset])) >>> FRAC_BITS;
        end
        r.clipped = 1'b0;
        if (acc > one) begin
            acc       = one;
            r.clipped = 1'b1;
        end else if (acc < -one) begin
            acc       = -one;
            r.clipped = 1'b1;
        end
        r.neuron_out = q14_t'(acc);
        return r;
    endfunction

    // mostly in range, some raw 16-bit patterns and corner values
    function automatic q14_t rand_q14();
        q14_t v;
        case ($urandom_range(0, 9))
            6, 7: v = q14_t'($urandom);
            8: begin
                case ($urandom_range(0, 5))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = 16'sh4000;
                    3: v = -16'sh4000;
                    4: v = 16'sh0000;
                    default: v = -16'sh0001;
                endcase
            end
            9: v = q14_t'($urandom_range(0, 64)) - 16'sd32;
            default: v = q14_t'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // call only after a rising edge with the pipe empty
    task automatic program_coeffs();
        int i;
        for (i = 0; i < COEFF_COUNT; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= coeff_idx_t'(i);
            cfg_wdata <= coeff_plan[i];
            @(posedge aclk);
            coeff_regs[i] = coeff_plan[i];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic fill_plan(input q14_t v);
        int i;
        for (i = 0; i < COEFF_COUNT; i++) begin
            coeff_plan[i] = v;
        end
    endtask

    task automatic send_beat(input q14_t a, input q14_t b, input q14_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_in_a  <= a;
        s_in_b  <= b;
        s_in_c  <= c;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_neuron(a, b, c));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (stall_left % 3) != 0;
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        neuron_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (m_neuron_out !== want.neuron_out) begin
                    report_mismatch($sformatf("neuron_out %0d, want %0d",
                                              m_neuron_out, want.neuron_out));
                end
                if (m_clipped !== want.clipped) begin
                    report_mismatch($sformatf("clipped %0b, want %0b",
                                              m_clipped, want.clipped));
                end
            end
        end
    end

    // coefficients still at reset, output must be zero
    task automatic test_reset_coeffs();
        send_beat(16'sh7FFF, 16'sh8000, 16'sh4000);
        send_beat(-16'sh4000, -16'sh0001, 16'sh0000);
        wait_drained();
    endtask

    // each subset term alone, with negative products to check floor rounding
    task automatic test_single_terms();
        int idx;
        for (idx = 0; idx < COEFF_COUNT; idx++) begin
            fill_plan(16'sh0000);
            coeff_plan[idx] = (idx % 2 == 0) ? 16'sh4000 : -16'sh2A5B;
            program_coeffs();
            send_beat(16'sh3039, -16'sh2AF3, -16'sh0007);
            wait_drained();
        end
    endtask

    // exact +/-1.0 passes unclamped, beyond it clamps
    task automatic test_saturation();
        fill_plan(16'sh0000);
        coeff_plan[IDX_BIAS] = 16'sh4000;
        program_coeffs();
        send_beat(16'sh0000, 16'sh0000, 16'sh0000);
        wait_drained();

        coeff_plan[IDX_BIAS] = -16'sh4000;
        program_coeffs();
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        wait_drained();

        fill_plan(16'sh4000);
        program_coeffs();
        send_beat(16'sh4000, 16'sh4000, 16'sh4000);
        send_beat(-16'sh4000, -16'sh4000, -16'sh4000);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000);
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        wait_drained();

        fill_plan(16'sh8000);
        program_coeffs();
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_beat(16'sh8000, 16'sh7FFF, 16'sh8000);
        wait_drained();

        fill_plan(16'sh7FFF);
        program_coeffs();
        send_beat(-16'sh0001, -16'sh0001, -16'sh0001);
        send_beat(16'sh8000, 16'sh8000, 16'sh7FFF);
        wait_drained();
    endtask

    task automatic test_random(input int phases, input int beats_per_phase);
        int p;
        int n;
        int i;
        for (p = 0; p < phases; p++) begin
            case (p)
                0: fill_plan(16'sh7FFF);
                1: fill_plan(16'sh8000);
                2: fill_plan(16'sh4000);
                3: fill_plan(-16'sh4000);
                default: begin
                    for (i = 0; i < COEFF_COUNT; i++) begin
                        coeff_plan[i] = rand_q14();
                    end
                end
            endcase
            program_coeffs();
            for (n = 0; n < beats_per_phase; n++) begin
                send_beat(rand_q14(), rand_q14(), rand_q14());
            end
            wait_drained();
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < COEFF_COUNT; i++) begin
            coeff_regs[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_coeffs();
        test_single_terms();
        test_saturation();
        test_random(10, 85);

        if (pending_results.size() != 0) begin
            report_mismatch("results still pending at end of run");
        end
        if (error_count == 0) begin
            $display("[multilinear_neuron_eval] OK");
        end else begin
            $display("[multilinear_neuron_eval] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: multilinear_neuron_eval.f
src/mne_pkg.sv
src/mne_coeff_regs.sv
src/multilinear_neuron_eval.sv
sim/testbench.sv
